/* rtl/ppsa_pkg.sv */
// Shared types and constants for the payload patch stream applier.
// Holds the phase encoding, result codes and configuration register indexes.
// No dependencies.
package ppsa_pkg;

    localparam int unsigned PAYLOAD_BYTES_DEFAULT = 1024;
    localparam int unsigned ADDR_W = 10;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned WORD_W = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_LANGUAGE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_VARIANT  = 8'd1;

    typedef enum logic [1:0] {
        KIND_WRITE     = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_NOT_FOUND = 2'd2,
        KIND_RANGE     = 2'd3
    } kind_t;

    typedef enum logic [8:0] {
        PH_BASE_HDR   = 9'b000000001,
        PH_BASE_DATA  = 9'b000000010,
        PH_VAR_HDR    = 9'b000000100,
        PH_PATCH_SIZE = 9'b000001000,
        PH_PATCH_OFS  = 9'b000010000,
        PH_PATCH_DATA = 9'b000100000,
        PH_ALIGN      = 9'b001000000,
        PH_PENDING    = 9'b010000000,
        PH_DONE       = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] data;
    } ppsa_result_t;

endpackage

/* rtl/ppsa_if.sv */
// Channel interfaces for the payload patch stream applier.
// Depends on ppsa_pkg for field widths.
interface ppsa_byte_if
    import ppsa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] file_byte;
    logic              last_in_file;

    modport source (output valid, output file_byte, output last_in_file, input ready);
    modport sink (input valid, input file_byte, input last_in_file, output ready);
endinterface

interface ppsa_result_if
    import ppsa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;

    modport source (output valid, output kind, output address, output data, input ready);
    modport sink (input valid, input kind, input address, input data, output ready);
endinterface

interface ppsa_cfg_if
    import ppsa_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

/* rtl/payload_patch_stream_applier_unit.sv */
// Top level of the payload patch stream applier: input register, parser,
// result register and configuration registers.
// Depends on ppsa_pkg, the channel interfaces in ppsa_if and ppsa_parser.
//
//  channel     direction  payload                         handshake
//  file_in     in         file_byte[7:0], last_in_file    valid / ready
//  result_out  out        kind[1:0], address[9:0], data   valid / ready
//  cfg         in         index[7:0], wdata[7:0]          valid / ready
//
// One file byte is taken per cycle when the result side keeps up.
// A byte is registered at acceptance and its result, if any, is registered
// in the result register when the parser steps on that byte.
// Reset clears the parser to expect a base header and both registers empty.
// A stalled result holds the byte behind it, and ready drops only when both
// the input and result registers are full.
module payload_patch_stream_applier_unit
    import ppsa_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT
)
(
    input logic           clk,
    input logic           rst_n,
    ppsa_byte_if.sink     file_in,
    ppsa_result_if.source result_out,
    ppsa_cfg_if.sink      cfg
);

    logic              in_vld_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              out_vld_reg;
    kind_t             kind_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] lang_reg;
    logic [BYTE_W-1:0] var_reg;
    logic              advance;
    ppsa_result_t      res;

    assign advance       = in_vld_reg && (!out_vld_reg || result_out.ready);
    assign file_in.ready = !in_vld_reg || advance;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (file_in.ready)
        begin
            in_vld_reg <= file_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (file_in.valid && file_in.ready)
        begin
            byte_reg <= file_in.file_byte;
            last_reg <= file_in.last_in_file;
        end
    end

    ppsa_parser #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .file_byte       (byte_reg),
        .last_in_file    (last_reg),
        .wanted_language (lang_reg),
        .wanted_variant  (var_reg),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= res.valid;
        end
        else if (result_out.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            kind_reg <= res.kind;
            addr_reg <= res.address;
            data_reg <= res.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lang_reg <= '0;
            var_reg  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == CFG_WANTED_LANGUAGE)
            begin
                lang_reg <= cfg.wdata;
            end
            else if (cfg.index == CFG_WANTED_VARIANT)
            begin
                var_reg <= cfg.wdata;
            end
        end
    end

    assign result_out.valid   = out_vld_reg;
    assign result_out.kind    = kind_reg;
    assign result_out.address = addr_reg;
    assign result_out.data    = data_reg;

    // The parser only moves when the result register has room.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !out_vld_reg || result_out.ready)
        else $error("parser advanced into a full result register");

    // Status transactions carry zero address and data.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && kind_reg != KIND_WRITE |-> addr_reg == '0 && data_reg == '0)
        else $error("status transaction with nonzero address or data");

    // A byte waiting behind a stalled result is kept.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !advance |=> in_vld_reg && $stable(byte_reg) && $stable(last_reg))
        else $error("waiting file byte was lost");

endmodule

/* rtl/ppsa_parser.sv */
// File parser of the payload patch stream applier: phase register, field
// counters and the per-byte next-state and result logic.
// Depends on ppsa_pkg.
module ppsa_parser
    import ppsa_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] file_byte,
    input  logic              last_in_file,
    input  logic [BYTE_W-1:0] wanted_language,
    input  logic [BYTE_W-1:0] wanted_variant,
    output ppsa_result_t      res
);

    localparam logic [WORD_W:0] PAYLOAD_LIM = (WORD_W+1)'(PAYLOAD_BYTES);

    phase_t            phase_reg, phase_next;
    logic [WORD_W-1:0] pos_reg, pos_next;
    logic [1:0]        idx_reg, idx_next;
    logic [BYTE_W-1:0] lang_reg, lang_next;
    logic [BYTE_W-1:0] var_reg, var_next;
    logic [WORD_W-1:0] count_reg, count_next;
    logic [WORD_W-1:0] len_reg, len_next;
    logic [WORD_W-1:0] start_reg, start_next;
    logic [WORD_W-1:0] left_reg, left_next;
    logic [WORD_W-1:0] wp_reg, wp_next;
    logic              match_reg, match_next;

    logic  wrote;
    logic  rec_done;
    logic  pat_done;
    logic  fin;
    logic  advance_rec;
    kind_t fin_kind;

    function automatic phase_t after_record(logic [WORD_W-1:0] pos, logic [WORD_W-1:0] cnt);
        phase_t ph;
        if (pos[1:0] != 2'd0)
        begin
            ph = PH_ALIGN;
        end
        else if (cnt != '0)
        begin
            ph = PH_PATCH_SIZE;
        end
        else
        begin
            ph = PH_VAR_HDR;
        end
        return ph;
    endfunction

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg + 1'b1;
        idx_next    = idx_reg;
        lang_next   = lang_reg;
        var_next    = var_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        start_next  = start_reg;
        left_next   = left_reg;
        wp_next     = wp_reg;
        match_next  = match_reg;
        res         = '0;
        wrote       = 1'b0;
        rec_done    = 1'b0;
        pat_done    = 1'b0;
        fin         = 1'b0;
        advance_rec = 1'b0;
        fin_kind    = KIND_FOUND;

        unique case (phase_reg)
            PH_BASE_HDR, PH_VAR_HDR:
            begin
                idx_next = idx_reg + 1'b1;
                unique case (idx_reg)
                    2'd0: lang_next = file_byte;
                    2'd1: var_next = file_byte;
                    2'd2: count_next = {{(WORD_W-BYTE_W){1'b0}}, file_byte};
                    default:
                    begin
                        count_next = {file_byte, count_reg[BYTE_W-1:0]};
                        match_next = (lang_reg == wanted_language) &&
                                     (var_reg == wanted_variant);
                        left_next  = count_next;
                        wp_next    = '0;
                        if (count_next == '0)
                        begin
                            rec_done = 1'b1;
                        end
                        else if (phase_reg == PH_BASE_HDR)
                        begin
                            phase_next = PH_BASE_DATA;
                        end
                        else
                        begin
                            phase_next = PH_PATCH_SIZE;
                        end
                    end
                endcase
            end
            PH_BASE_DATA:
            begin
                wrote = {1'b0, wp_reg} < PAYLOAD_LIM;
                if (wrote)
                begin
                    res.valid   = 1'b1;
                    res.kind    = KIND_WRITE;
                    res.address = wp_reg[ADDR_W-1:0];
                    res.data    = file_byte;
                end
                wp_next   = wp_reg + 1'b1;
                left_next = left_reg - 1'b1;
                if (left_next == '0)
                begin
                    count_next = '0;
                    rec_done   = 1'b1;
                end
            end
            PH_PATCH_SIZE:
            begin
                if (idx_reg == 2'd0)
                begin
                    len_next = {{(WORD_W-BYTE_W){1'b0}}, file_byte};
                    idx_next = 2'd1;
                end
                else
                begin
                    len_next   = {file_byte, len_reg[BYTE_W-1:0]};
                    idx_next   = 2'd0;
                    phase_next = PH_PATCH_OFS;
                end
            end
            PH_PATCH_OFS:
            begin
                if (idx_reg == 2'd0)
                begin
                    start_next = {{(WORD_W-BYTE_W){1'b0}}, file_byte};
                    idx_next   = 2'd1;
                end
                else
                begin
                    start_next = {file_byte, start_reg[BYTE_W-1:0]};
                    idx_next   = 2'd0;
                    if (match_reg &&
                        (({1'b0, start_next} + {1'b0, len_reg}) > PAYLOAD_LIM))
                    begin
                        fin      = 1'b1;
                        fin_kind = KIND_RANGE;
                    end
                    else if (len_reg == '0)
                    begin
                        pat_done = 1'b1;
                    end
                    else
                    begin
                        left_next  = len_reg;
                        wp_next    = '0;
                        phase_next = PH_PATCH_DATA;
                    end
                end
            end
            PH_PATCH_DATA:
            begin
                wrote = match_reg;
                if (match_reg)
                begin
                    res.valid   = 1'b1;
                    res.kind    = KIND_WRITE;
                    res.address = start_reg[ADDR_W-1:0] + wp_reg[ADDR_W-1:0];
                    res.data    = file_byte;
                end
                wp_next   = wp_reg + 1'b1;
                left_next = left_reg - 1'b1;
                if (left_next == '0)
                begin
                    pat_done = 1'b1;
                end
            end
            PH_ALIGN:
            begin
                if (pos_next[1:0] == 2'd0)
                begin
                    advance_rec = 1'b1;
                end
            end
            PH_PENDING:
            begin
                fin      = 1'b1;
                fin_kind = KIND_FOUND;
            end
            default:
            begin
            end
        endcase

        if (pat_done)
        begin
            count_next = count_next - 1'b1;
            if (count_next == '0)
            begin
                rec_done = 1'b1;
            end
            else
            begin
                advance_rec = 1'b1;
            end
        end

        if (rec_done)
        begin
            if (match_next)
            begin
                if (wrote)
                begin
                    phase_next = PH_PENDING;
                end
                else
                begin
                    fin      = 1'b1;
                    fin_kind = KIND_FOUND;
                end
            end
            else
            begin
                advance_rec = 1'b1;
            end
        end

        if (advance_rec)
        begin
            idx_next   = 2'd0;
            phase_next = after_record(pos_next, count_next);
        end

        if (fin)
        begin
            phase_next = PH_DONE;
            res        = '0;
            res.valid  = 1'b1;
            res.kind   = fin_kind;
        end

        if (last_in_file)
        begin
            if ((phase_next != PH_DONE) && !res.valid)
            begin
                res.valid = 1'b1;
                res.kind  = KIND_NOT_FOUND;
            end
            phase_next = PH_BASE_HDR;
            pos_next   = '0;
            idx_next   = 2'd0;
            lang_next  = '0;
            var_next   = '0;
            count_next = '0;
            len_next   = '0;
            start_next = '0;
            left_next  = '0;
            wp_next    = '0;
            match_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BASE_HDR;
            pos_reg   <= '0;
            idx_reg   <= '0;
            lang_reg  <= '0;
            var_reg   <= '0;
            count_reg <= '0;
            len_reg   <= '0;
            start_reg <= '0;
            left_reg  <= '0;
            wp_reg    <= '0;
            match_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            lang_reg  <= lang_next;
            var_reg   <= var_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            left_reg  <= left_next;
            wp_reg    <= wp_next;
            match_reg <= match_next;
        end
    end

    // A file's last byte always leaves the parser ready for a new base header.
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_in_file |=> phase_reg == PH_BASE_HDR && pos_reg == '0)
        else $error("parser did not restart after the last byte of a file");

    // Once a status is out, no further result comes before the file ends.
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_DONE |-> !res.valid)
        else $error("result produced after the final status");

    // Patch data of a record that does not match the wanted language and variant never becomes a write.
    a_skip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_PATCH_DATA && !match_reg |->
            !res.valid || res.kind != KIND_WRITE)
        else $error("write issued for a skipped patch");

endmodule
